[hdl/tpr_pkg.sv]
`timescale 1ns / 1ps

package tpr_pkg;

    // Grid geometry and field widths.
    localparam int GRID_SIZE = 32;
    localparam int POS_W     = $clog2(GRID_SIZE);
    localparam int OP_W      = 3;
    localparam int DIST_W    = 7;
    localparam int SEL_W     = 5;
    localparam int HEAD_W    = 2;
    localparam int ROW_OUT_W = 32;
    localparam int POS_OUT_W = 5;

    // Signed width that holds a position plus or minus any distance.
    localparam int MOVE_W = DIST_W + POS_W + 1;

    localparam logic [POS_W-1:0]         POS_MAX = POS_W'(GRID_SIZE - 1);
    localparam logic signed [MOVE_W-1:0] EDGE_S  = MOVE_W'(GRID_SIZE - 1);

    // Command queue between the front and the back.
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // Operation codes of the input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_PEN_UP    = 3'd0,
        OP_PEN_DOWN  = 3'd1,
        OP_TURN_R    = 3'd2,
        OP_TURN_L    = 3'd3,
        OP_MOVE      = 3'd4,
        OP_CLEAR     = 3'd5,
        OP_READ_ROW  = 3'd6
    } op_t;

    // Grid work that the back has to carry out for one command.
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_HLINE = 3'd1,
        K_VLINE = 3'd2,
        K_CLEAR = 3'd3,
        K_READ  = 3'd4
    } kind_t;

    // Turtle status reported with each result.
    typedef struct packed {
        logic              off;
        logic              pen;
        logic [HEAD_W-1:0] heading;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } stat_t;

    // One classified command. For a line, line is the fixed coordinate and
    // lo..hi the span along the other axis; for a read, line is the row.
    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] line;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
        stat_t            stat;
    } cmd_t;

endpackage

[hdl/tpr_front.sv]
`timescale 1ns / 1ps

module tpr_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [tpr_pkg::OP_W-1:0]    operation,
    input  logic [tpr_pkg::DIST_W-1:0]  distance,
    input  logic [tpr_pkg::SEL_W-1:0]   row_select,
    output tpr_pkg::cmd_t               cmd
);

    logic                         pen_reg, pen_next;
    logic [tpr_pkg::HEAD_W-1:0]   heading_reg, heading_next;
    logic [tpr_pkg::POS_W-1:0]    row_reg, row_next;
    logic [tpr_pkg::POS_W-1:0]    col_reg, col_next;

    logic                               vertical;
    logic                               negative;
    logic [tpr_pkg::POS_W-1:0]          start_pos;
    logic signed [tpr_pkg::MOVE_W-1:0]  p_s;
    logic signed [tpr_pkg::MOVE_W-1:0]  d_s;
    logic signed [tpr_pkg::MOVE_W-1:0]  target;
    logic signed [tpr_pkg::MOVE_W-1:0]  last;
    logic                               clipped;
    logic [tpr_pkg::POS_W-1:0]          end_pos;
    logic [tpr_pkg::POS_W-1:0]          last_pos;

    // Saturate a signed coordinate to the grid.
    function automatic logic [tpr_pkg::POS_W-1:0] clamp_pos(
        input logic signed [tpr_pkg::MOVE_W-1:0] v
    );
        logic [tpr_pkg::POS_W-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > tpr_pkg::EDGE_S)
        begin
            r = tpr_pkg::POS_MAX;
        end
        else
        begin
            r = v[tpr_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    // Move geometry: heading bit 0 selects the row axis, bit 1 a negative step.
    always_comb
    begin
        vertical  = heading_reg[0];
        negative  = heading_reg[1];
        start_pos = vertical ? row_reg : col_reg;
        p_s       = $signed(tpr_pkg::MOVE_W'(start_pos));
        d_s       = $signed(tpr_pkg::MOVE_W'(distance));
        target    = negative ? (p_s - d_s) : (p_s + d_s);
        last      = negative ? tpr_pkg::MOVE_W'(p_s - d_s + 1)
                             : tpr_pkg::MOVE_W'(p_s + d_s - 1);
        clipped   = (target < 0) || (target > tpr_pkg::EDGE_S);
        end_pos   = clamp_pos(target);
        last_pos  = clamp_pos(last);
    end

    // Classify the command and work out the turtle state after it.
    always_comb
    begin
        pen_next     = pen_reg;
        heading_next = heading_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        cmd.kind     = tpr_pkg::K_NONE;
        cmd.line     = '0;
        cmd.lo       = '0;
        cmd.hi       = '0;
        cmd.stat.off = 1'b0;
        case (operation)
            tpr_pkg::OP_PEN_UP:   pen_next = 1'b0;
            tpr_pkg::OP_PEN_DOWN: pen_next = 1'b1;
            tpr_pkg::OP_TURN_R:   heading_next = heading_reg + 2'd1;
            tpr_pkg::OP_TURN_L:   heading_next = heading_reg - 2'd1;
            tpr_pkg::OP_MOVE:
            begin
                if (pen_reg && (distance != '0))
                begin
                    cmd.kind = vertical ? tpr_pkg::K_VLINE : tpr_pkg::K_HLINE;
                    cmd.line = vertical ? col_reg : row_reg;
                    cmd.lo   = negative ? last_pos : start_pos;
                    cmd.hi   = negative ? start_pos : last_pos;
                end
                if (vertical)
                begin
                    row_next = end_pos;
                end
                else
                begin
                    col_next = end_pos;
                end
                cmd.stat.off = clipped;
            end
            tpr_pkg::OP_CLEAR:    cmd.kind = tpr_pkg::K_CLEAR;
            tpr_pkg::OP_READ_ROW:
            begin
                if (int'(row_select) < tpr_pkg::GRID_SIZE)
                begin
                    cmd.kind = tpr_pkg::K_READ;
                    cmd.line = tpr_pkg::POS_W'(row_select);
                end
            end
            default: ;
        endcase
        cmd.stat.pen     = pen_next;
        cmd.stat.heading = heading_next;
        cmd.stat.row     = row_next;
        cmd.stat.col     = col_next;
    end

    // Turtle state advances on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg     <= 1'b0;
            heading_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
        end
        else if (accept)
        begin
            pen_reg     <= pen_next;
            heading_reg <= heading_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
        end
    end

endmodule

[hdl/tpr_cmd_queue.sv]
`timescale 1ns / 1ps

module tpr_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tpr_pkg::cmd_t wr_cmd,
    input  logic          rd_en,
    output logic          q_full,
    output logic          q_empty,
    output tpr_pkg::cmd_t rd_cmd
);

    tpr_pkg::cmd_t                  entry_reg [tpr_pkg::CQ_DEPTH];
    logic [tpr_pkg::CQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [tpr_pkg::CQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [tpr_pkg::CQ_CNT_W-1:0]   count_reg, count_next;
    logic                           do_wr;
    logic                           do_rd;

    localparam logic [tpr_pkg::CQ_PTR_W-1:0] PTR_LAST =
        tpr_pkg::CQ_PTR_W'(tpr_pkg::CQ_DEPTH - 1);
    localparam logic [tpr_pkg::CQ_CNT_W-1:0] CNT_FULL =
        tpr_pkg::CQ_CNT_W'(tpr_pkg::CQ_DEPTH);

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign rd_cmd  = entry_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;

    // Pointer and occupancy bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[hdl/tpr_back.sv]
`timescale 1ns / 1ps

module tpr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  tpr_pkg::cmd_t                   head,
    output logic                            q_pop,
    input  logic                            res_pop,
    output logic                            res_valid,
    output logic [tpr_pkg::ROW_OUT_W-1:0]   res_row,
    output tpr_pkg::stat_t                  res_stat
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_VLINE = 2'b10
    } state_t;

    state_t                             state_reg, state_next;
    logic [tpr_pkg::GRID_SIZE-1:0]      grid_reg [tpr_pkg::GRID_SIZE];
    logic [tpr_pkg::POS_W-1:0]          vrow_reg, vrow_next;
    logic [tpr_pkg::POS_W-1:0]          vcol_reg;
    logic [tpr_pkg::POS_W-1:0]          vhi_reg;
    tpr_pkg::stat_t                     vstat_reg;
    logic                               out_valid_reg, out_valid_next;
    logic [tpr_pkg::ROW_OUT_W-1:0]      out_row_reg;
    tpr_pkg::stat_t                     out_stat_reg;

    logic                               out_free;
    logic                               emit;
    logic                               load_vline;
    logic [tpr_pkg::ROW_OUT_W-1:0]      emit_row;
    tpr_pkg::stat_t                     emit_stat;
    logic                               wr_en;
    logic                               clr;
    logic [tpr_pkg::POS_W-1:0]          wr_idx;
    logic [tpr_pkg::GRID_SIZE-1:0]      wr_mask;
    logic [tpr_pkg::GRID_SIZE-1:0]      span_mask;

    localparam logic [tpr_pkg::GRID_SIZE-1:0] ALL_ONES = '1;

    assign out_free  = !out_valid_reg || res_pop;
    assign res_valid = out_valid_reg;
    assign res_row   = out_row_reg;
    assign res_stat  = out_stat_reg;

    // Columns lo..hi of a horizontal line.
    assign span_mask = (ALL_ONES << head.lo) & (ALL_ONES >> (tpr_pkg::POS_MAX - head.hi));

    // Execution sequencer: a vertical line is marked one row per cycle; other commands
    // are popped and carried out once the result register is free.
    always_comb
    begin
        state_next = state_reg;
        vrow_next  = vrow_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        load_vline = 1'b0;
        emit_row   = '0;
        emit_stat  = head.stat;
        wr_en      = 1'b0;
        clr        = 1'b0;
        wr_idx     = head.line;
        wr_mask    = span_mask;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.kind == tpr_pkg::K_VLINE)
                    begin
                        q_pop      = 1'b1;
                        load_vline = 1'b1;
                        vrow_next  = head.lo;
                        state_next = ST_VLINE;
                    end
                    else if (out_free)
                    begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                        case (head.kind)
                            tpr_pkg::K_HLINE: wr_en = 1'b1;
                            tpr_pkg::K_CLEAR: clr = 1'b1;
                            tpr_pkg::K_READ:
                                emit_row = tpr_pkg::ROW_OUT_W'(grid_reg[head.line]);
                            default: ;
                        endcase
                    end
                end
            end
            ST_VLINE:
            begin
                wr_en     = 1'b1;
                wr_idx    = vrow_reg;
                wr_mask   = tpr_pkg::GRID_SIZE'(1) << vcol_reg;
                emit_stat = vstat_reg;
                if (vrow_reg != vhi_reg)
                begin
                    vrow_next = vrow_reg + 1'b1;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result register toward the output side.
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Vertical line context and result payload.
    always_ff @(posedge clk)
    begin
        vrow_reg <= vrow_next;
        if (load_vline)
        begin
            vcol_reg  <= head.line;
            vhi_reg   <= head.hi;
            vstat_reg <= head.stat;
        end
        if (emit)
        begin
            out_row_reg  <= emit_row;
            out_stat_reg <= emit_stat;
        end
    end

    // Grid storage: cleared at reset and by the clear command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpr_pkg::GRID_SIZE; i++)
            begin
                grid_reg[i] <= '0;
            end
        end
        else if (clr)
        begin
            for (int i = 0; i < tpr_pkg::GRID_SIZE; i++)
            begin
                grid_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            grid_reg[wr_idx] <= grid_reg[wr_idx] | wr_mask;
        end
    end

endmodule

[hdl/turtle_plotter_raster.sv]
// Turtle-graphics plotter on a 32 x 32 bit grid.
// Input channel: a command transaction (operation, distance, row_select) is
// taken when push is high and full is low. Result channel: one result per
// command, in command order; it is shown while empty is low and taken when
// pop is high and empty is low.
// The front decodes each command and updates pen, heading and position at
// once, then places the grid work in a four-entry command queue. The back
// drains that queue: pen, turn, clear, read and horizontal moves are done in the
// cycle they are popped, a vertical move marks one grid row per cycle.
// Sustained rate: one command per cycle while results are popped and no
// vertical move is being marked.
// A held result (pop low) keeps the back from finishing further commands;
// the queue then fills and full rises until pop is given.
// Reset clears the grid, raises the pen, faces right at row 0, column 0,
// and empties the queue and the result register.
`timescale 1ns / 1ps

module turtle_plotter_raster (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [tpr_pkg::OP_W-1:0]        operation,
    input  logic [tpr_pkg::DIST_W-1:0]      distance,
    input  logic [tpr_pkg::SEL_W-1:0]       row_select,
    output logic                            empty,
    input  logic                            pop,
    output logic [tpr_pkg::ROW_OUT_W-1:0]   row_bits,
    output logic                            off_grid,
    output logic                            pen_is_down,
    output logic [tpr_pkg::HEAD_W-1:0]      heading_now,
    output logic [tpr_pkg::POS_OUT_W-1:0]   pos_row,
    output logic [tpr_pkg::POS_OUT_W-1:0]   pos_col
);

    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           accept;
    logic           res_valid;
    tpr_pkg::cmd_t  front_cmd;
    tpr_pkg::cmd_t  head_cmd;
    tpr_pkg::stat_t res_stat;

    assign accept = push && !q_full;
    assign full   = q_full;

    tpr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .distance   (distance),
        .row_select (row_select),
        .cmd        (front_cmd)
    );

    tpr_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_cmd  (front_cmd),
        .rd_en   (q_pop),
        .q_full  (q_full),
        .q_empty (q_empty),
        .rd_cmd  (head_cmd)
    );

    tpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head_cmd),
        .q_pop     (q_pop),
        .res_pop   (pop && res_valid),
        .res_valid (res_valid),
        .res_row   (row_bits),
        .res_stat  (res_stat)
    );

    // Result fields at their port widths.
    assign empty       = !res_valid;
    assign off_grid    = res_stat.off;
    assign pen_is_down = res_stat.pen;
    assign heading_now = res_stat.heading;
    assign pos_row     = tpr_pkg::POS_OUT_W'(res_stat.row);
    assign pos_col     = tpr_pkg::POS_OUT_W'(res_stat.col);

endmodule

[hdl/tpr_checker.sv]
`timescale 1ns / 1ps

module tpr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             empty,
    input logic                             pop,
    input logic [tpr_pkg::ROW_OUT_W-1:0]    row_bits,
    input logic                             off_grid,
    input logic [tpr_pkg::POS_OUT_W-1:0]    pos_row,
    input logic [tpr_pkg::POS_OUT_W-1:0]    pos_col
);

    localparam logic [tpr_pkg::POS_OUT_W-1:0] EDGE_OUT =
        tpr_pkg::POS_OUT_W'(tpr_pkg::GRID_SIZE - 1);

    // A clock edge under reset leaves no result on offer.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result offered after a reset edge");

    // A result that is not taken stays and keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(row_bits) && $stable(off_grid)
                              && $stable(pos_row) && $stable(pos_col)))
        else $error("stalled result changed");

    // Only a move can be clipped, and a move returns no row bits.
    a_off_no_row: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && off_grid) |-> (row_bits == '0))
        else $error("clipped move carried row bits");

    // A clipped move leaves the turtle on an edge of the grid.
    a_off_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && off_grid) |-> (pos_row == '0 || pos_row == EDGE_OUT
                                  || pos_col == '0 || pos_col == EDGE_OUT))
        else $error("clipped move not at grid edge");

endmodule

bind turtle_plotter_raster tpr_checker u_tpr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .row_bits (row_bits),
    .off_grid (off_grid),
    .pos_row  (pos_row),
    .pos_col  (pos_col)
);

[verif/tb_turtle_plotter_raster.sv]
`timescale 1ns / 1ps

module tb_turtle_plotter_raster;

    // Heading codes as the plotter reports them.
    localparam logic [tpr_pkg::HEAD_W-1:0] HEAD_RIGHT = 2'd0;
    localparam logic [tpr_pkg::HEAD_W-1:0] HEAD_DOWN  = 2'd1;
    localparam logic [tpr_pkg::HEAD_W-1:0] HEAD_LEFT  = 2'd2;
    localparam logic [tpr_pkg::HEAD_W-1:0] HEAD_UP    = 2'd3;

    // The one operation code that the plotter leaves unused.
    localparam logic [tpr_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    // Receiver stall patterns.
    localparam int POP_ALWAYS   = 0;
    localparam int POP_COIN     = 1;
    localparam int POP_SPARSE   = 2;
    localparam int POP_PERIODIC = 3;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 1750;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [tpr_pkg::OP_W-1:0]   op;
        logic [tpr_pkg::DIST_W-1:0] move_len;
        logic [tpr_pkg::SEL_W-1:0]  sel;
    } plot_cmd_t;

    typedef struct packed {
        logic [tpr_pkg::ROW_OUT_W-1:0] row_bits;
        logic                          off;
        logic                          pen;
        logic [tpr_pkg::HEAD_W-1:0]    heading;
        logic [tpr_pkg::POS_OUT_W-1:0] row;
        logic [tpr_pkg::POS_OUT_W-1:0] col;
    } plot_result_t;

    typedef struct packed {
        plot_cmd_t    cmd;
        logic         typed;
        plot_result_t want;
    } directed_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [tpr_pkg::OP_W-1:0]       operation = '0;
    logic [tpr_pkg::DIST_W-1:0]     distance = '0;
    logic [tpr_pkg::SEL_W-1:0]      row_select = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [tpr_pkg::ROW_OUT_W-1:0]  row_bits;
    logic                           off_grid;
    logic                           pen_is_down;
    logic [tpr_pkg::HEAD_W-1:0]     heading_now;
    logic [tpr_pkg::POS_OUT_W-1:0]  pos_row;
    logic [tpr_pkg::POS_OUT_W-1:0]  pos_col;

    // Plotter state as the testbench tracks it.
    logic [tpr_pkg::GRID_SIZE-1:0]  grid_image [tpr_pkg::GRID_SIZE];
    logic                           pen_state;
    logic [tpr_pkg::HEAD_W-1:0]     heading_state;
    int                             turtle_row;
    int                             turtle_col;

    plot_result_t          expected_results [$];
    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    burst_left = 0;
    int                    pop_mode = POP_ALWAYS;
    int                    pop_mode_left = 0;

    // Directed commands; a typed expectation is given where it is obvious.
    directed_row_t directed_cmds [N_DIRECTED] = '{
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd0}, 1'b1,
          '{32'h0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd31}, 1'b1,
          '{32'h0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0}},
        '{'{OP_UNUSED, 7'd127, 5'd31}, 1'b1,
          '{32'h0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_MOVE, 7'd0, 5'd0}, 1'b1,
          '{32'h0, 1'b0, 1'b0, HEAD_RIGHT, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_PEN_DOWN, 7'd0, 5'd0}, 1'b1,
          '{32'h0, 1'b0, 1'b1, HEAD_RIGHT, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_TURN_L, 7'd0, 5'd0}, 1'b1,
          '{32'h0, 1'b0, 1'b1, HEAD_UP, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_MOVE, 7'd5, 5'd0}, 1'b1,
          '{32'h0, 1'b1, 1'b1, HEAD_UP, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd0}, 1'b1,
          '{32'h1, 1'b0, 1'b1, HEAD_UP, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_TURN_R, 7'd0, 5'd0}, 1'b1,
          '{32'h0, 1'b0, 1'b1, HEAD_RIGHT, 5'd0, 5'd0}},
        '{'{tpr_pkg::OP_MOVE, 7'd127, 5'd0}, 1'b1,
          '{32'h0, 1'b1, 1'b1, HEAD_RIGHT, 5'd0, 5'd31}},
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd0}, 1'b1,
          '{32'hFFFF_FFFF, 1'b0, 1'b1, HEAD_RIGHT, 5'd0, 5'd31}},
        '{'{tpr_pkg::OP_TURN_R, 7'd0, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_MOVE, 7'd99, 5'd0}, 1'b1,
          '{32'h0, 1'b1, 1'b1, HEAD_DOWN, 5'd31, 5'd31}},
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd31}, 1'b1,
          '{32'h8000_0000, 1'b0, 1'b1, HEAD_DOWN, 5'd31, 5'd31}},
        '{'{tpr_pkg::OP_TURN_R, 7'd0, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_MOVE, 7'd31, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd31}, 1'b0, '0},
        '{'{tpr_pkg::OP_TURN_R, 7'd0, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_PEN_UP, 7'd0, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_MOVE, 7'd10, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd21}, 1'b0, '0},
        '{'{tpr_pkg::OP_CLEAR, 7'd0, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_READ_ROW, 7'd0, 5'd31}, 1'b0, '0},
        '{'{tpr_pkg::OP_TURN_L, 7'd0, 5'd0}, 1'b0, '0},
        '{'{tpr_pkg::OP_MOVE, 7'd1, 5'd0}, 1'b0, '0}
    };

    turtle_plotter_raster dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .distance    (distance),
        .row_select  (row_select),
        .empty       (empty),
        .pop         (pop),
        .row_bits    (row_bits),
        .off_grid    (off_grid),
        .pen_is_down (pen_is_down),
        .heading_now (heading_now),
        .pos_row     (pos_row),
        .pos_col     (pos_col)
    );

    always #5 clk = ~clk;

    // Apply one command to the tracked plotter state and return its result.
    function automatic plot_result_t plot_command(input plot_cmd_t cmd);
        plot_result_t res;
        int step_row;
        int step_col;
        int cell_row;
        int cell_col;
        int span;
        res = '0;
        case (cmd.op)
            tpr_pkg::OP_PEN_UP:   pen_state = 1'b0;
            tpr_pkg::OP_PEN_DOWN: pen_state = 1'b1;
            tpr_pkg::OP_TURN_R:   heading_state = heading_state + 2'd1;
            tpr_pkg::OP_TURN_L:   heading_state = heading_state - 2'd1;
            tpr_pkg::OP_MOVE:
            begin
                step_row = (heading_state == HEAD_DOWN) ? 1 :
                           (heading_state == HEAD_UP) ? -1 : 0;
                step_col = (heading_state == HEAD_RIGHT) ? 1 :
                           (heading_state == HEAD_LEFT) ? -1 : 0;
                span = int'(cmd.move_len);
                // Mark the path; cells past the edge are dropped.
                if (pen_state)
                begin
                    for (int i = 0; i < span; i++)
                    begin
                        cell_row = turtle_row + step_row * i;
                        cell_col = turtle_col + step_col * i;
                        if (cell_row >= 0 && cell_row < tpr_pkg::GRID_SIZE &&
                            cell_col >= 0 && cell_col < tpr_pkg::GRID_SIZE)
                            grid_image[cell_row][cell_col] = 1'b1;
                    end
                end
                // The end position saturates at the edge it crossed.
                turtle_row = turtle_row + step_row * span;
                turtle_col = turtle_col + step_col * span;
                if (turtle_row < 0 || turtle_row > tpr_pkg::GRID_SIZE - 1 ||
                    turtle_col < 0 || turtle_col > tpr_pkg::GRID_SIZE - 1)
                    res.off = 1'b1;
                if (turtle_row < 0) turtle_row = 0;
                if (turtle_row > tpr_pkg::GRID_SIZE - 1) turtle_row = tpr_pkg::GRID_SIZE - 1;
                if (turtle_col < 0) turtle_col = 0;
                if (turtle_col > tpr_pkg::GRID_SIZE - 1) turtle_col = tpr_pkg::GRID_SIZE - 1;
            end
            tpr_pkg::OP_CLEAR:
            begin
                for (int r = 0; r < tpr_pkg::GRID_SIZE; r++)
                    grid_image[r] = '0;
            end
            tpr_pkg::OP_READ_ROW:
            begin
                if (int'(cmd.sel) < tpr_pkg::GRID_SIZE)
                    res.row_bits = grid_image[cmd.sel];
            end
            default: ;
        endcase
        res.pen = pen_state;
        res.heading = heading_state;
        res.row = tpr_pkg::POS_OUT_W'(turtle_row);
        res.col = tpr_pkg::POS_OUT_W'(turtle_col);
        return res;
    endfunction

    // Random command; moves dominate and mostly stay short so that
    // the turtle wanders over the grid instead of pinning at an edge.
    function automatic plot_cmd_t random_command();
        plot_cmd_t cmd;
        int pick;
        int span_pick;
        pick = $urandom_range(0, 99);
        span_pick = $urandom_range(0, 99);
        cmd.sel = tpr_pkg::SEL_W'($urandom_range(0, 31));
        if (span_pick < 70)
            cmd.move_len = tpr_pkg::DIST_W'($urandom_range(0, 12));
        else if (span_pick < 92)
            cmd.move_len = tpr_pkg::DIST_W'($urandom_range(0, 40));
        else
            cmd.move_len = tpr_pkg::DIST_W'($urandom_range(0, 127));
        if (pick < 38)
            cmd.op = tpr_pkg::OP_MOVE;
        else if (pick < 49)
            cmd.op = tpr_pkg::OP_TURN_R;
        else if (pick < 60)
            cmd.op = tpr_pkg::OP_TURN_L;
        else if (pick < 70)
            cmd.op = tpr_pkg::OP_PEN_DOWN;
        else if (pick < 76)
            cmd.op = tpr_pkg::OP_PEN_UP;
        else if (pick < 97)
        begin
            cmd.op = tpr_pkg::OP_READ_ROW;
            // Half of the reads look at the row the turtle is on.
            if ($urandom_range(0, 1) == 0)
                cmd.sel = tpr_pkg::SEL_W'(turtle_row);
        end
        else if (pick < 98)
            cmd.op = tpr_pkg::OP_CLEAR;
        else
            cmd.op = OP_UNUSED;
        return cmd;
    endfunction

    // Present one command, hold it until the plotter takes it, and
    // record what the transaction should produce.
    task automatic issue_command(input plot_cmd_t cmd, input logic typed,
                                 input plot_result_t want);
        plot_result_t predicted;
        push       <= 1'b1;
        operation  <= cmd.op;
        distance   <= cmd.move_len;
        row_select <= cmd.sel;
        do
            @(posedge clk);
        while (full !== 1'b0);
        predicted = plot_command(cmd);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Sender bursts: count down the burst, then usually idle for a random gap.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[turtle_plotter_raster] ERROR");
            $finish;
        end
    end

    // Receiver: switch to a randomly chosen stall pattern whenever the current one runs out.
    always @(posedge clk)
    begin
        if (pop_mode_left == 0)
        begin
            pop_mode <= $urandom_range(POP_ALWAYS, POP_PERIODIC);
            pop_mode_left <= $urandom_range(50, 300);
        end
        else
            pop_mode_left <= pop_mode_left - 1;
        case (pop_mode)
            POP_ALWAYS:   pop <= 1'b1;
            POP_COIN:     pop <= 1'($urandom_range(0, 1));
            POP_SPARSE:   pop <= ($urandom_range(0, 7) == 0);
            default:      pop <= cycle_count[2];
        endcase
    end

    // Check every result transaction against the oldest expectation.
    always @(posedge clk)
    begin
        plot_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no command outstanding");
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("row_bits", want.row_bits, row_bits);
                check_field("off_grid", 32'(want.off), 32'(off_grid));
                check_field("pen_is_down", 32'(want.pen), 32'(pen_is_down));
                check_field("heading_now", 32'(want.heading), 32'(heading_now));
                check_field("pos_row", 32'(want.row), 32'(pos_row));
                check_field("pos_col", 32'(want.col), 32'(pos_col));
            end
        end
    end

    initial
    begin
        for (int r = 0; r < tpr_pkg::GRID_SIZE; r++)
            grid_image[r] = '0;
        pen_state = 1'b0;
        heading_state = HEAD_RIGHT;
        turtle_row = 0;
        turtle_col = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands from the table.
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            issue_command(directed_cmds[i].cmd, directed_cmds[i].typed,
                          directed_cmds[i].want);
            pace_sender();
        end

        // Random commands.
        for (int i = 0; i < N_RANDOM; i++)
        begin
            issue_command(random_command(), 1'b0, '0);
            pace_sender();
        end
        push <= 1'b0;

        // Drain, then give the plotter time to show any stray result.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("[turtle_plotter_raster] OK");
        else
            $display("[turtle_plotter_raster] ERROR");
        $finish;
    end

endmodule
